// ===== hdl/rrcpsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rrcpsi_pkg
// shared types, widths and codes of the rrc pulse shaping interpolator
// ----------------------------------------------------------------------------
package rrcpsi_pkg;

    localparam int DEF_MAX_SPS  = 16;
    localparam int DEF_MAX_SPAN = 16;
    localparam int DEF_MAX_TAPS = 256;

    localparam int SAMP_W    = 16;
    localparam int TAP_W     = 18;
    localparam int TIDX_W    = 8;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 32;

    typedef enum logic {
        OP_SYMBOL = 1'b0,
        OP_TAP    = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPS  = 1'b0,
        CFG_SPAN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic hist_shift;
        logic tap_we;
        logic mac_valid;
        logic mac_first;
        logic mac_last;
        logic sym_last;
    } t_cmd;

    typedef struct packed {
        logic sample_loaded;
    } t_sts;

endpackage

// ===== hdl/rrcpsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrcpsi_ctrl
// config registers and sequencer: while a sample is summed, one mac per cycle over span taps per sample
// ----------------------------------------------------------------------------
module rrcpsi_ctrl #(
    parameter int MAX_SPS  = rrcpsi_pkg::DEF_MAX_SPS,
    parameter int MAX_SPAN = rrcpsi_pkg::DEF_MAX_SPAN,
    parameter int POS_W    = 9,
    parameter int J_W      = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [rrcpsi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rrcpsi_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_op,
    output logic                           o_in_ready,
    output rrcpsi_pkg::t_cmd               o_cmd,
    output logic [POS_W-1:0]               o_rd_pos,
    output logic [J_W-1:0]                 o_rd_j,
    input  rrcpsi_pkg::t_sts               i_sts
);
    import rrcpsi_pkg::*;

    localparam int SPS_W  = $clog2(MAX_SPS + 1);
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);
    localparam int K_W    = (MAX_SPS > 1) ? $clog2(MAX_SPS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_sps_raw;
    logic [CFG_W-1:0]   r_span_raw;
    logic [K_W-1:0]     r_k;
    logic [J_W-1:0]     r_j;
    logic [POS_W-1:0]   r_pos;
    logic [SPS_W-1:0]   sps_c;
    logic [SPAN_W-1:0]  span_c;
    logic               accept;
    logic               j_last;
    logic               k_last;

    always_comb begin
        if (r_sps_raw == '0) begin
            sps_c = SPS_W'(1);
        end else if (int'(r_sps_raw) > MAX_SPS) begin
            sps_c = SPS_W'(MAX_SPS);
        end else begin
            sps_c = SPS_W'(r_sps_raw);
        end
        if (r_span_raw == '0) begin
            span_c = SPAN_W'(1);
        end else if (int'(r_span_raw) > MAX_SPAN) begin
            span_c = SPAN_W'(MAX_SPAN);
        end else begin
            span_c = SPAN_W'(r_span_raw);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign j_last     = (SPAN_W'(r_j) + SPAN_W'(1)) == span_c;
    assign k_last     = (SPS_W'(r_k) + SPS_W'(1)) == sps_c;

    assign o_cmd.hist_shift = accept && (t_op'(i_in_op) == OP_SYMBOL);
    assign o_cmd.tap_we     = accept && (t_op'(i_in_op) == OP_TAP);
    assign o_cmd.mac_valid  = (r_state == S_RUN);
    assign o_cmd.mac_first  = (r_j == '0);
    assign o_cmd.mac_last   = j_last;
    assign o_cmd.sym_last   = k_last;
    assign o_rd_pos         = r_pos;
    assign o_rd_j           = r_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sps_raw  <= CFG_W'(8);
            r_span_raw <= CFG_W'(8);
            r_k        <= '0;
            r_j        <= '0;
            r_pos      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SPS:  r_sps_raw  <= i_cfg_data;
                    CFG_SPAN: r_span_raw <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.hist_shift) begin
                        r_state <= S_RUN;
                        r_k     <= '0;
                        r_j     <= '0;
                        r_pos   <= '0;
                    end
                end
                S_RUN: begin
                    r_j   <= r_j + J_W'(1);
                    r_pos <= r_pos + POS_W'(sps_c);
                    if (j_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (i_sts.sample_loaded) begin
                        if (k_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RUN;
                            r_k     <= r_k + K_W'(1);
                            r_j     <= '0;
                            r_pos   <= POS_W'(r_k) + POS_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_load_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.sample_loaded |-> r_state == S_DRAIN)
        else $error("sample loaded outside drain");
    a_run_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && j_last) |=> r_state == S_DRAIN)
        else $error("last tap not followed by drain");
    a_symbol_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.hist_shift |=> (r_state == S_RUN && r_k == '0 && r_pos == '0))
        else $error("symbol did not start at sample zero");

endmodule

// ===== hdl/rrcpsi_dp.sv =====
// ----------------------------------------------------------------------------
// rrcpsi_dp
// tap memory, symbol history, complex mac pipeline, rounding and output word
// ----------------------------------------------------------------------------
module rrcpsi_dp #(
    parameter int MAX_SPAN = rrcpsi_pkg::DEF_MAX_SPAN,
    parameter int MAX_TAPS = rrcpsi_pkg::DEF_MAX_TAPS,
    parameter int POS_W    = 9,
    parameter int J_W      = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rrcpsi_pkg::t_cmd                    i_cmd,
    input  logic [POS_W-1:0]                    i_rd_pos,
    input  logic [J_W-1:0]                      i_rd_j,
    input  logic signed [rrcpsi_pkg::SAMP_W-1:0] i_sym_i,
    input  logic signed [rrcpsi_pkg::SAMP_W-1:0] i_sym_q,
    input  logic [rrcpsi_pkg::TIDX_W-1:0]       i_tap_index,
    input  logic signed [rrcpsi_pkg::TAP_W-1:0] i_tap_value,
    output rrcpsi_pkg::t_sts                    o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rrcpsi_pkg::SAMP_W-1:0]       o_out_i,
    output logic [rrcpsi_pkg::SAMP_W-1:0]       o_out_q,
    output logic                                o_out_last
);
    import rrcpsi_pkg::*;

    localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PROD_W = SAMP_W + TAP_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_SPAN) + 1;

    logic signed [TAP_W-1:0]  r_tap_mem [MAX_TAPS];
    logic signed [SAMP_W-1:0] r_hist_i  [MAX_SPAN];
    logic signed [SAMP_W-1:0] r_hist_q  [MAX_SPAN];

    logic signed [TAP_W-1:0]  r_tap_rd;
    logic signed [SAMP_W-1:0] r_h_i;
    logic signed [SAMP_W-1:0] r_h_q;
    logic                     r_in1;
    logic                     r_v1;
    logic                     r_first1;
    logic                     r_last1;
    logic                     r_sym1;

    logic signed [PROD_W-1:0] r_p_i;
    logic signed [PROD_W-1:0] r_p_q;
    logic                     r_v2;
    logic                     r_first2;
    logic                     r_last2;
    logic                     r_sym2;

    logic signed [ACC_W-1:0]  r_acc_i;
    logic signed [ACC_W-1:0]  r_acc_q;
    logic                     r_acc_full;
    logic                     r_acc_sym;

    logic                     r_out_valid;
    logic [SAMP_W-1:0]        r_out_i;
    logic [SAMP_W-1:0]        r_out_q;
    logic                     r_out_last;

    logic signed [TAP_W-1:0]  tap_m;
    logic                     load;

    function automatic logic [SAMP_W-1:0] f_round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] r;
        logic signed [ACC_W:0] hi;
        logic signed [ACC_W:0] lo;
        v  = (ACC_W+1)'(a) + (ACC_W+1)'(65536);
        r  = v >>> 17;
        hi = (ACC_W+1)'(32767);
        lo = -(ACC_W+1)'(32768);
        if (r > hi) begin
            return SAMP_W'(hi);
        end else if (r < lo) begin
            return SAMP_W'(lo);
        end
        return SAMP_W'(r);
    endfunction

    // tap store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_we && (int'(i_tap_index) < MAX_TAPS)) begin
            r_tap_mem[TAP_AW'(i_tap_index)] <= i_tap_value;
        end
        r_tap_rd <= r_tap_mem[TAP_AW'(i_rd_pos)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < MAX_SPAN; n++) begin
                r_hist_i[n] <= '0;
                r_hist_q[n] <= '0;
            end
        end else if (i_cmd.hist_shift) begin
            for (int n = MAX_SPAN - 1; n > 0; n--) begin
                r_hist_i[n] <= r_hist_i[n-1];
                r_hist_q[n] <= r_hist_q[n-1];
            end
            r_hist_i[0] <= i_sym_i;
            r_hist_q[0] <= i_sym_q;
        end
    end

    assign tap_m = r_in1 ? r_tap_rd : '0;
    assign load  = r_acc_full && (!r_out_valid || i_out_ready);

    // payload stages
    always_ff @(posedge i_clk) begin
        r_h_i    <= r_hist_i[i_rd_j];
        r_h_q    <= r_hist_q[i_rd_j];
        r_in1    <= int'(i_rd_pos) < MAX_TAPS;
        r_first1 <= i_cmd.mac_first;
        r_last1  <= i_cmd.mac_last;
        r_sym1   <= i_cmd.sym_last;
        r_p_i    <= r_h_i * tap_m;
        r_p_q    <= r_h_q * tap_m;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_sym2   <= r_sym1;
        if (r_v2) begin
            r_acc_i <= (r_first2 ? ACC_W'(0) : r_acc_i) + ACC_W'(r_p_i);
            r_acc_q <= (r_first2 ? ACC_W'(0) : r_acc_q) + ACC_W'(r_p_q);
            if (r_last2) begin
                r_acc_sym <= r_sym2;
            end
        end
        if (load) begin
            r_out_i    <= f_round_sat(r_acc_i);
            r_out_q    <= f_round_sat(r_acc_q);
            r_out_last <= r_acc_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_acc_full  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_valid;
            r_v2 <= r_v1;
            if (r_v2 && r_last2) begin
                r_acc_full <= 1'b1;
            end else if (load) begin
                r_acc_full <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.sample_loaded = load;
    assign o_out_valid         = r_out_valid;
    assign o_out_i             = r_out_i;
    assign o_out_q             = r_out_q;
    assign o_out_last          = r_out_last;

    a_no_mac_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> !r_acc_full)
        else $error("mac product arrived while sum waits");
    a_sum_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_full && !load) |=> (r_acc_full && $stable(r_acc_i) && $stable(r_acc_q)))
        else $error("waiting sum lost");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid)
        else $error("loaded sample not presented");

endmodule

// ===== hdl/rrc_pulse_shaping_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// rrc_pulse_shaping_interpolator_core
// complex polyphase interpolating fir (root raised cosine pulse shaper)
// ----------------------------------------------------------------------------
// s_axis carries one word per symbol or tap load; tuser selects the kind:
// a tap load writes one coefficient and gives no output, a symbol enters the
// history and gives samples_per_symbol words on m_axis, the final one with
// tlast set. the cfg channel sets samples_per_symbol (index 0) and
// filter_span (index 1); write it only while the block is idle.
// one complex mac (two 16x18 multipliers) runs per cycle over a three stage
// pipe (read, multiply, accumulate) while a sample is summed; between samples
// the sequencer waits until the finished sum enters the output register.
// s_axis_tready is high only while no symbol is being worked on; the output
// register lets the next symbol be accepted while the last word still waits.
// when m_axis_tready is low the finished sample is held and the mac sequencer
// waits, nothing is dropped. reset clears the history to zero and sets both
// registers to 8; tap memory has no reset and must be loaded before use.
// ----------------------------------------------------------------------------
module rrc_pulse_shaping_interpolator_core #(
    parameter int MAX_SPS  = rrcpsi_pkg::DEF_MAX_SPS,
    parameter int MAX_SPAN = rrcpsi_pkg::DEF_MAX_SPAN,
    parameter int MAX_TAPS = rrcpsi_pkg::DEF_MAX_TAPS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rrcpsi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rrcpsi_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sym_i[15:0], sym_q[31:16], tap_index[39:32], tap_value[57:40], zero[63:58]
    input  logic [rrcpsi_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // op[0]
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_i[15:0], out_q[31:16]
    output logic [rrcpsi_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import rrcpsi_pkg::*;

    localparam int POS_W = $clog2(MAX_SPS * MAX_SPAN + MAX_SPS + 1);
    localparam int J_W   = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

    t_cmd             cmd;
    t_sts             sts;
    logic [POS_W-1:0] rd_pos;
    logic [J_W-1:0]   rd_j;
    logic [SAMP_W-1:0] out_i;
    logic [SAMP_W-1:0] out_q;

    assign o_cfg_ready = 1'b1;

    rrcpsi_ctrl #(
        .MAX_SPS  (MAX_SPS),
        .MAX_SPAN (MAX_SPAN),
        .POS_W    (POS_W),
        .J_W      (J_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd),
        .o_rd_pos    (rd_pos),
        .o_rd_j      (rd_j),
        .i_sts       (sts)
    );

    rrcpsi_dp #(
        .MAX_SPAN (MAX_SPAN),
        .MAX_TAPS (MAX_TAPS),
        .POS_W    (POS_W),
        .J_W      (J_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_pos    (rd_pos),
        .i_rd_j      (rd_j),
        .i_sym_i     (s_axis_tdata[15:0]),
        .i_sym_q     (s_axis_tdata[31:16]),
        .i_tap_index (s_axis_tdata[39:32]),
        .i_tap_value (s_axis_tdata[57:40]),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_i     (out_i),
        .o_out_q     (out_q),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_q, out_i};

endmodule

// ===== dv/rrc_pulse_shaping_interpolator_core_tb.sv =====
// ----------------------------------------------------------------------------
// rrc_pulse_shaping_interpolator_core_tb
// self-checking bench for the complex polyphase rrc interpolator
// ----------------------------------------------------------------------------
// a queue of tap loads and symbols feeds a stream driver; every accepted word
// runs through a bit-true filter predictor in the bench (tap mirror, 16 deep
// symbol history, round half up and saturation), which queues the samples the
// block owes. the monitor pops and compares each output word. the run walks
// through several register settings, out-of-range values and extremes among
// them, with three pacing patterns on the two stream sides. registers are
// only written after the pipe has drained.
// ----------------------------------------------------------------------------
module rrc_pulse_shaping_interpolator_core_tb;
    import rrcpsi_pkg::*;

    localparam int IDLE_GAP   = 32;
    localparam int TAIL_WAIT  = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        PACE_SRC_LIGHT,
        PACE_SRC_HEAVY,
        PACE_NONE
    } t_pace;

    typedef struct packed {
        t_op               op;
        logic [TAP_W-1:0]  tap_value;
        logic [TIDX_W-1:0] tap_index;
        logic [SAMP_W-1:0] sym_q;
        logic [SAMP_W-1:0] sym_i;
    } t_in_word;

    typedef struct packed {
        logic [SAMP_W-1:0] out_q;
        logic [SAMP_W-1:0] out_i;
        logic              out_last;
    } t_sample;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // sym_i[15:0], sym_q[31:16], tap_index[39:32], tap_value[57:40], zero[63:58]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // op[0]
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_i[15:0], out_q[31:16]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    rrc_pulse_shaping_interpolator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state
    logic signed [TAP_W-1:0]  tap_mirror [DEF_MAX_TAPS];
    logic signed [SAMP_W-1:0] hist_i [DEF_MAX_SPAN];
    logic signed [SAMP_W-1:0] hist_q [DEF_MAX_SPAN];
    logic [CFG_W-1:0]         sps_reg = 5'd8;
    logic [CFG_W-1:0]         span_reg = 5'd8;

    // stimulus side bookkeeping
    bit       tap_loaded [DEF_MAX_TAPS];
    t_in_word pending_words [$];
    t_sample  expected_samples [$];
    t_in_word drv_word;
    t_pace    pace = PACE_NONE;

    int n_symbols = 0;
    int n_taps = 0;
    int n_samples = 0;
    int n_saturated = 0;
    int n_cfg = 0;
    int n_errors = 0;
    int stall_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        for (int h = 0; h < DEF_MAX_SPAN; h++) begin
            hist_i[h] = '0;
            hist_q[h] = '0;
        end
    end

    function automatic int unsigned eff_reg(logic [CFG_W-1:0] raw, int unsigned hi);
        if (raw == 0) return 1;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic logic [SAMP_W-1:0] round_q15(longint acc);
        longint r;
        r = (acc + 64'sd65536) >>> 17;
        if (r > 32767) begin
            r = 32767;
            n_saturated++;
        end else if (r < -32768) begin
            r = -32768;
            n_saturated++;
        end
        return r[SAMP_W-1:0];
    endfunction

    function automatic void note_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function automatic bit stall_roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int src_pct(t_pace p);
        case (p)
            PACE_SRC_LIGHT: return 37;
            PACE_SRC_HEAVY: return 57;
            default:        return 0;
        endcase
    endfunction

    function automatic int dst_pct(t_pace p);
        case (p)
            PACE_SRC_LIGHT: return 57;
            PACE_SRC_HEAVY: return 37;
            default:        return 0;
        endcase
    endfunction

    // filter predictor: applies one accepted word, queues the samples it owes
    task automatic compute_samples(t_in_word w);
        int unsigned sps;
        int unsigned span;
        int unsigned pos;
        longint acc_i;
        longint acc_q;
        t_sample s;
        if (w.op == OP_TAP) begin
            if (w.tap_index < DEF_MAX_TAPS) tap_mirror[w.tap_index] = w.tap_value;
            n_taps++;
        end else begin
            for (int h = DEF_MAX_SPAN - 1; h > 0; h--) begin
                hist_i[h] = hist_i[h-1];
                hist_q[h] = hist_q[h-1];
            end
            hist_i[0] = w.sym_i;
            hist_q[0] = w.sym_q;
            sps = eff_reg(sps_reg, DEF_MAX_SPS);
            span = eff_reg(span_reg, DEF_MAX_SPAN);
            for (int unsigned k = 0; k < sps; k++) begin
                acc_i = 0;
                acc_q = 0;
                for (int unsigned j = 0; j < span; j++) begin
                    pos = k + j * sps;
                    if (pos < DEF_MAX_TAPS) begin
                        acc_i += longint'(hist_i[j]) * longint'(tap_mirror[pos]);
                        acc_q += longint'(hist_q[j]) * longint'(tap_mirror[pos]);
                    end
                end
                s.out_i = round_q15(acc_i);
                s.out_q = round_q15(acc_q);
                s.out_last = (k + 1 == sps);
                expected_samples.push_back(s);
            end
            n_symbols++;
        end
    endtask

    // stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                compute_samples(drv_word);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() != 0 && !stall_roll(src_pct(pace))) begin
                    drv_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'b0, drv_word.tap_value, drv_word.tap_index,
                                     drv_word.sym_q, drv_word.sym_i};
                    s_axis_tuser <= drv_word.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_samples++;
                if (expected_samples.size() == 0) begin
                    note_error($sformatf("unexpected word i %0d q %0d last %b",
                        $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                        m_axis_tlast));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_axis_tdata !== {want.out_q, want.out_i}
                        || m_axis_tlast !== want.out_last) begin
                        note_error($sformatf(
                            "word %0d: expected i %0d q %0d last %b, got i %0d q %0d last %b",
                            n_samples, $signed(want.out_i), $signed(want.out_q),
                            want.out_last, $signed(m_axis_tdata[15:0]),
                            $signed(m_axis_tdata[31:16]), m_axis_tlast));
                    end
                end
            end
            m_axis_tready <= !stall_roll(dst_pct(pace));
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", stall_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [SAMP_W-1:0] rand_sample();
        case ($urandom_range(5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [TAP_W-1:0] rand_tap_value();
        case ($urandom_range(5))
            0:       return 18'h1ffff;
            1:       return 18'h20000;
            2:       return 18'($urandom_range(8191)) - 18'd4096;
            default: return 18'($urandom);
        endcase
    endfunction

    task automatic queue_tap(int unsigned idx, logic [TAP_W-1:0] value);
        t_in_word w;
        w.op = OP_TAP;
        w.tap_index = idx[TIDX_W-1:0];
        w.tap_value = value;
        w.sym_i = 16'($urandom);
        w.sym_q = 16'($urandom);
        tap_loaded[idx] = 1'b1;
        pending_words.push_back(w);
    endtask

    // loads any tap the current setting reads before sending the symbol
    task automatic queue_symbol(logic [SAMP_W-1:0] si, logic [SAMP_W-1:0] sq);
        int unsigned need;
        t_in_word w;
        need = eff_reg(sps_reg, DEF_MAX_SPS) * eff_reg(span_reg, DEF_MAX_SPAN);
        if (need > DEF_MAX_TAPS) need = DEF_MAX_TAPS;
        for (int unsigned p = 0; p < need; p++) begin
            if (!tap_loaded[p]) queue_tap(p, rand_tap_value());
        end
        w.op = OP_SYMBOL;
        w.sym_i = si;
        w.sym_q = sq;
        w.tap_index = 8'($urandom);
        w.tap_value = 18'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_samples.size() != 0);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SPS:  sps_reg = value;
            CFG_SPAN: span_reg = value;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic random_items(int n);
        @(negedge i_clk);
        repeat (n) begin
            if ($urandom_range(99) < 20) queue_tap($urandom_range(255), rand_tap_value());
            else queue_symbol(rand_sample(), rand_sample());
        end
    endtask

    // the drain in the middle holds the sender until all samples are back
    task automatic run_segment(t_pace p, logic [CFG_W-1:0] sps, logic [CFG_W-1:0] span,
                               int n);
        write_reg(CFG_SPS, sps);
        write_reg(CFG_SPAN, span);
        pace = p;
        random_items(n / 2);
        drain();
        random_items(n - n / 2);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 4 samples per symbol, span 2
        write_reg(CFG_SPS, 5'd4);
        write_reg(CFG_SPAN, 5'd2);
        @(negedge i_clk);
        queue_tap(0, 18'h1ffff);
        queue_tap(1, 18'h20000);
        queue_tap(2, 18'h10000);
        queue_tap(3, 18'h00000);
        queue_tap(4, 18'h00001);
        queue_tap(5, 18'h3ffff);
        queue_tap(6, 18'h30000);
        queue_tap(7, 18'h12345);
        // zero history then +1/-1 lsb against half-scale taps: round half up
        queue_symbol(16'h0000, 16'h0000);
        queue_symbol(16'h0001, 16'hffff);
        queue_symbol(16'h7fff, 16'h8000);
        queue_symbol(16'h8000, 16'h7fff);
        queue_symbol(16'h8000, 16'h8000);
        queue_symbol(16'hffff, 16'h0001);
        queue_tap(1, 18'h1ffff);
        queue_tap(6, 18'h20000);
        queue_symbol(16'h8000, 16'h8000);
        drain();

        run_segment(PACE_SRC_LIGHT, 5'd2, 5'd3, 30);
        run_segment(PACE_SRC_LIGHT, 5'd0, 5'd31, 25);
        run_segment(PACE_SRC_LIGHT, 5'd8, 5'd8, 25);
        run_segment(PACE_SRC_HEAVY, 5'd16, 5'd1, 25);
        run_segment(PACE_SRC_HEAVY, 5'd31, 5'd5, 20);
        run_segment(PACE_SRC_HEAVY, 5'd3, 5'd17, 25);
        run_segment(PACE_NONE, 5'd16, 5'd6, 12);
        run_segment(PACE_NONE, 5'd1, 5'd0, 25);
        run_segment(PACE_NONE, 5'd5, 5'd12, 25);

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (expected_samples.size() != 0)
            note_error($sformatf("%0d samples never arrived", expected_samples.size()));

        $display("%0d symbols and %0d tap loads in, %0d samples out (%0d saturated parts)",
                 n_symbols, n_taps, n_samples, n_saturated);
        $display("%0d register writes over 10 settings, %0d mismatches", n_cfg, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
